[src/lzf_stream_decompressor_unit_defines.svh]
// ----------------------------------------------------------------------------
// LZF stream decompressor assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef LZF_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZF_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LZFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzfd same-cycle check failed");

// Next-cycle implication, disabled during reset
`define LZFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzfd next-cycle check failed");

`endif

[src/lzfd_pkg.sv]
// ----------------------------------------------------------------------------
// LZF stream decompressor package
// Shared constants, command format and state types.
// ----------------------------------------------------------------------------
package lzfd_pkg;

  localparam int HISTORY_DEPTH    = 8192;
  localparam int BYTES_PER_RESULT = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [7:0] LIT_LIMIT     = 8'(1 << 5);
  localparam logic [4:0] OFF_HIGH_MASK = 5'h1f;
  localparam logic [2:0] LONG_CODE     = 3'd7;
  localparam logic [8:0] SHORT_BIAS    = 9'd2;
  localparam logic [8:0] LONG_BIAS     = 9'd9;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CORRUPT = 2'd1;
  localparam logic [1:0] STATUS_SMALL   = 2'd2;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_LIT,
    PH_LEN,
    PH_OFF
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LIT_START,
    CMD_LIT_BYTE,
    CMD_COPY
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD,
    BK_WR,
    BK_FLUSH
  } back_state_t;

  // One classified compressed byte
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [8:0]  len;
    logic [13:0] distance;
    logic        last;
    logic        trunc;
  } cmd_t;

endpackage

[src/lzfd_ram.sv]
// ----------------------------------------------------------------------------
// LZF decompressor generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lzfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/lzfd_front.sv]
// ----------------------------------------------------------------------------
// LZF decompressor front end
// Parses compressed bytes into tokens and classifies each byte as a command.
// ----------------------------------------------------------------------------
module lzfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          stream_end,
  input  logic          q_full,
  output logic          q_push,
  output lzfd_pkg::cmd_t q_cmd
);

  lzfd_pkg::phase_t phase, phase_next;
  logic [5:0] lit_rem, lit_rem_next;
  logic [8:0] copy_len, copy_len_next;
  logic [4:0] off_high, off_high_next;
  logic       take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign q_push   = take;

  // Classify the byte and advance the token parser
  always_comb begin
    phase_next    = phase;
    lit_rem_next  = lit_rem;
    copy_len_next = copy_len;
    off_high_next = off_high;
    q_cmd         = '0;
    q_cmd.kind    = lzfd_pkg::CMD_NOP;
    q_cmd.data    = in_byte;
    q_cmd.last    = stream_end;
    case (phase)
      lzfd_pkg::PH_CTRL: begin
        if (in_byte < lzfd_pkg::LIT_LIMIT) begin
          lit_rem_next = 6'(in_byte) + 6'd1;
          q_cmd.kind   = lzfd_pkg::CMD_LIT_START;
          q_cmd.len    = 9'(in_byte) + 9'd1;
          phase_next   = lzfd_pkg::PH_LIT;
        end else begin
          off_high_next = in_byte[4:0] & lzfd_pkg::OFF_HIGH_MASK;
          if (in_byte[7:5] == lzfd_pkg::LONG_CODE) begin
            phase_next = lzfd_pkg::PH_LEN;
          end else begin
            copy_len_next = 9'(in_byte[7:5]) + lzfd_pkg::SHORT_BIAS;
            phase_next    = lzfd_pkg::PH_OFF;
          end
        end
      end
      lzfd_pkg::PH_LIT: begin
        q_cmd.kind   = lzfd_pkg::CMD_LIT_BYTE;
        lit_rem_next = lit_rem - 6'd1;
        if (lit_rem <= 6'd1) begin
          lit_rem_next = '0;
          phase_next   = lzfd_pkg::PH_CTRL;
        end
      end
      lzfd_pkg::PH_LEN: begin
        copy_len_next = 9'(in_byte) + lzfd_pkg::LONG_BIAS;
        phase_next    = lzfd_pkg::PH_OFF;
      end
      default: begin
        q_cmd.kind     = lzfd_pkg::CMD_COPY;
        q_cmd.len      = copy_len;
        q_cmd.distance = {1'b0, off_high, in_byte} + 14'd1;
        phase_next     = lzfd_pkg::PH_CTRL;
      end
    endcase
    q_cmd.trunc = stream_end && (phase_next != lzfd_pkg::PH_CTRL);
    // Stream boundary: restart the parser
    if (stream_end) begin
      phase_next = lzfd_pkg::PH_CTRL;
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= lzfd_pkg::PH_CTRL;
      lit_rem  <= '0;
      copy_len <= '0;
      off_high <= '0;
    end else if (take) begin
      phase    <= phase_next;
      lit_rem  <= lit_rem_next;
      copy_len <= copy_len_next;
      off_high <= off_high_next;
    end
  end

endmodule

[src/lzfd_queue.sv]
// ----------------------------------------------------------------------------
// LZF decompressor command queue
// Small FIFO that decouples the parser from the executor.
// ----------------------------------------------------------------------------
module lzfd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lzfd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lzfd_pkg::cmd_t head
);

  localparam int PW = $clog2(lzfd_pkg::QUEUE_DEPTH);

  lzfd_pkg::cmd_t entries [lzfd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(lzfd_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

[src/lzfd_back.sv]
// ----------------------------------------------------------------------------
// LZF decompressor back end
// Executes commands: history writes, copies, size counting, result packing.
// ----------------------------------------------------------------------------
module lzfd_back #(
  parameter int HISTORY_DEPTH    = lzfd_pkg::HISTORY_DEPTH,
  parameter int BYTES_PER_RESULT = lzfd_pkg::BYTES_PER_RESULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [31:0]    cfg_wr_data,
  input  logic           q_valid,
  input  lzfd_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [63:0]    data_bytes,
  output logic [3:0]     byte_count,
  output logic           end_of_run,
  output logic           stream_done,
  output logic [1:0]     status,
  output logic [31:0]    total_size
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [3:0] BPR = 4'(BYTES_PER_RESULT);
  localparam logic [AW:0] DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

  lzfd_pkg::back_state_t state, state_next;

  logic [31:0]   cap;
  logic [31:0]   pc, pc_next;
  logic          cnt_only, cnt_only_next;
  logic          err, err_next;
  logic [AW-1:0] wptr, wptr_next;
  logic [8:0]    rem, rem_next;
  logic [13:0]   copy_dist, copy_dist_next;
  logic          last_r, last_next;
  logic          trunc_r, trunc_next;
  logic [63:0]   pk, pk_next;
  logic [3:0]    pk_cnt, pk_cnt_next;

  logic          out_free;
  logic          emit;
  logic [63:0]   emit_data;
  logic [3:0]    emit_cnt;
  logic          emit_eor;
  logic          emit_done;
  logic [1:0]    emit_status;
  logic [31:0]   emit_total;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [AW:0]   rd_sum;
  logic [AW-1:0] wptr_inc;
  logic [32:0]   fit_sum, sat_sum;
  logic          fits_len;
  logic [63:0]   pk_add;
  logic          wr_last, wr_full;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == lzfd_pkg::BK_IDLE) && q_valid;

  // Address and arithmetic helpers
  assign wptr_inc  = (wptr == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr + AW'(1);
  assign rd_sum    = ({1'b0, wptr} >= (AW+1)'(copy_dist)) ?
                     {1'b0, wptr} - (AW+1)'(copy_dist) :
                     {1'b0, wptr} + DEPTH_EXT - (AW+1)'(copy_dist);
  assign ram_raddr = rd_sum[AW-1:0];
  assign fit_sum   = {1'b0, pc} + 33'(q_cmd.len);
  assign fits_len  = fit_sum <= {1'b0, cap};
  assign sat_sum   = {1'b0, pc} + 33'(q_cmd.len);
  assign pk_add    = pk | (64'(ram_rdata) << {pk_cnt, 3'b000});
  assign wr_last   = (rem == 9'd1);
  assign wr_full   = (pk_cnt == BPR - 4'd1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lzfd_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = lzfd_pkg::BK_FLUSH;
          if (!err && q_cmd.kind == lzfd_pkg::CMD_COPY && !cnt_only_next &&
              32'(q_cmd.distance) <= pc) begin
            state_next = lzfd_pkg::BK_RD;
          end
        end
      end
      lzfd_pkg::BK_RD: begin
        state_next = lzfd_pkg::BK_WR;
      end
      lzfd_pkg::BK_WR: begin
        if (wr_last) begin
          state_next = lzfd_pkg::BK_FLUSH;
        end else if (!wr_full || out_free) begin
          state_next = lzfd_pkg::BK_RD;
        end
      end
      default: begin
        if ((pk_cnt == '0 && !last_r) || out_free) begin
          state_next = lzfd_pkg::BK_IDLE;
        end
      end
    endcase
  end

  // Datapath and result assembly
  always_comb begin
    pc_next        = pc;
    cnt_only_next  = cnt_only;
    err_next       = err;
    wptr_next      = wptr;
    rem_next       = rem;
    copy_dist_next = copy_dist;
    last_next      = last_r;
    trunc_next     = trunc_r;
    pk_next        = pk;
    pk_cnt_next    = pk_cnt;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_wdata      = ram_rdata;
    emit           = 1'b0;
    emit_data      = pk;
    emit_cnt       = pk_cnt;
    emit_eor       = 1'b1;
    emit_done      = 1'b0;
    emit_status    = lzfd_pkg::STATUS_OK;
    emit_total     = '0;
    case (state)
      lzfd_pkg::BK_IDLE: begin
        if (q_valid) begin
          last_next      = q_cmd.last;
          trunc_next     = q_cmd.trunc;
          pk_next        = '0;
          pk_cnt_next    = '0;
          copy_dist_next = q_cmd.distance;
          rem_next       = q_cmd.len;
          if (!err) begin
            case (q_cmd.kind)
              lzfd_pkg::CMD_LIT_START: begin
                if (!cnt_only && !fits_len) begin
                  cnt_only_next = 1'b1;
                end
              end
              lzfd_pkg::CMD_LIT_BYTE: begin
                if (cnt_only) begin
                  pc_next = (pc == '1) ? pc : pc + 32'd1;
                end else begin
                  ram_we      = 1'b1;
                  ram_wdata   = q_cmd.data;
                  pc_next     = pc + 32'd1;
                  wptr_next   = wptr_inc;
                  pk_next     = 64'(q_cmd.data);
                  pk_cnt_next = 4'd1;
                end
              end
              lzfd_pkg::CMD_COPY: begin
                if (!cnt_only && !fits_len) begin
                  cnt_only_next = 1'b1;
                end
                if (cnt_only || !fits_len) begin
                  pc_next = sat_sum[32] ? '1 : sat_sum[31:0];
                end else if (32'(q_cmd.distance) > pc) begin
                  err_next = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      lzfd_pkg::BK_RD: begin
        ram_re = 1'b1;
      end
      lzfd_pkg::BK_WR: begin
        if (wr_last || !wr_full || out_free) begin
          ram_we    = 1'b1;
          pc_next   = pc + 32'd1;
          wptr_next = wptr_inc;
          rem_next  = rem - 9'd1;
          if (!wr_last && wr_full) begin
            // Word full with more to copy: send it on
            emit        = 1'b1;
            emit_data   = pk_add;
            emit_cnt    = BPR;
            emit_eor    = 1'b0;
            pk_next     = '0;
            pk_cnt_next = '0;
          end else begin
            pk_next     = pk_add;
            pk_cnt_next = pk_cnt + 4'd1;
          end
        end
      end
      default: begin
        if (!(pk_cnt == '0 && !last_r) && out_free) begin
          emit      = 1'b1;
          emit_done = last_r;
          if (last_r) begin
            if (err || trunc_r) begin
              emit_status = lzfd_pkg::STATUS_CORRUPT;
            end else begin
              emit_status = (cnt_only && cap != '0) ? lzfd_pkg::STATUS_SMALL :
                                                      lzfd_pkg::STATUS_OK;
              emit_total  = pc;
            end
            // Stream boundary: restart per-stream state
            pc_next       = '0;
            cnt_only_next = 1'b0;
            err_next      = 1'b0;
            wptr_next     = '0;
          end
        end
      end
    endcase
  end

  lzfd_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wptr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lzfd_pkg::BK_IDLE;
      cap      <= '1;
      pc       <= '0;
      cnt_only <= 1'b0;
      err      <= 1'b0;
      wptr     <= '0;
      pk_cnt   <= '0;
      last_r   <= 1'b0;
    end else begin
      state    <= state_next;
      pc       <= pc_next;
      cnt_only <= cnt_only_next;
      err      <= err_next;
      wptr     <= wptr_next;
      pk_cnt   <= pk_cnt_next;
      last_r   <= last_next;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem       <= rem_next;
    copy_dist <= copy_dist_next;
    trunc_r   <= trunc_next;
    pk        <= pk_next;
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_bytes  <= emit_data;
      byte_count  <= emit_cnt;
      end_of_run  <= emit_eor;
      stream_done <= emit_done;
      status      <= emit_status;
      total_size  <= emit_total;
    end
  end

endmodule

[src/lzf_stream_decompressor_unit.sv]
// With the executor idle, a literal byte goes from the queue through the
// executor's idle state to its flush state, which registers the result once
// the output is free. A back-reference reads then writes history per copied
// byte, which sets the copy rate; a 4-deep queue buffers input. Reset:
// synchronous; clears parser, queue, counters; capacity to all ones.
// History contents are not cleared.
// ----------------------------------------------------------------------------
// LZF stream decompressor
// Parser front end, command queue and executor with history memory.
// ----------------------------------------------------------------------------
module lzf_stream_decompressor_unit #(
  parameter int HISTORY_DEPTH    = lzfd_pkg::HISTORY_DEPTH,
  parameter int BYTES_PER_RESULT = lzfd_pkg::BYTES_PER_RESULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_bytes,
  output logic [3:0]  byte_count,
  output logic        end_of_run,
  output logic        stream_done,
  output logic [1:0]  status,
  output logic [31:0] total_size
);

  lzfd_pkg::cmd_t push_cmd, head_cmd;
  logic           q_full, q_push, q_pop, q_not_empty;

  lzfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .stream_end(stream_end),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  lzfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (head_cmd)
  );

  lzfd_back #(
    .HISTORY_DEPTH   (HISTORY_DEPTH),
    .BYTES_PER_RESULT(BYTES_PER_RESULT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_valid    (q_not_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_bytes (data_bytes),
    .byte_count (byte_count),
    .end_of_run (end_of_run),
    .stream_done(stream_done),
    .status     (status),
    .total_size (total_size)
  );

endmodule

[src/lzfd_checker.sv]
// ----------------------------------------------------------------------------
// LZF decompressor port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzf_stream_decompressor_unit_defines.svh"

module lzfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] data_bytes,
  input logic [3:0]  byte_count,
  input logic        end_of_run,
  input logic        stream_done,
  input logic [1:0]  status,
  input logic [31:0] total_size
);

  `LZFD_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(data_bytes))
  `LZFD_ASSERT_NOW(a_done_eor, clk, rst, out_valid && stream_done, end_of_run)
  `LZFD_ASSERT_NOW(a_count, clk, rst, out_valid, byte_count <= 4'd8)
  `LZFD_ASSERT_NOW(a_status, clk, rst, out_valid && !stream_done, status == lzfd_pkg::STATUS_OK && total_size == 32'd0)
  `LZFD_ASSERT_NOW(a_corrupt, clk, rst, out_valid && status == lzfd_pkg::STATUS_CORRUPT, total_size == 32'd0)

endmodule

bind lzf_stream_decompressor_unit lzfd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .data_bytes (data_bytes),
  .byte_count (byte_count),
  .end_of_run (end_of_run),
  .stream_done(stream_done),
  .status     (status),
  .total_size (total_size)
);
